FILE: hdl/affine_mac_with_chunk_saturation_unit_assert.svh
`ifndef AFFINE_MAC_WITH_CHUNK_SATURATION_UNIT_ASSERT_SVH
`define AFFINE_MAC_WITH_CHUNK_SATURATION_UNIT_ASSERT_SVH

// same-cycle implication, reset masked
`define AMCS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define AMCS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/amcs_pkg.sv
package amcs_pkg;

	localparam int LANES         = 8;
	localparam int STEP_SHIFT    = 4;
	localparam int MAX_CHUNK     = 4096;
	localparam int W_W           = 16;
	localparam int S_W           = 8;
	localparam int PROD_W        = W_W + S_W;
	localparam int CS_W          = 40;
	localparam int TOT_W         = 32;
	localparam int SUM_W         = CS_W + 1;
	localparam int CSTEP_W       = 13;
	localparam int CNT_W         = CSTEP_W + STEP_SHIFT;
	localparam int VC_W          = 4;
	localparam int WB_W          = 2;
	localparam int IDX_W         = 2;
	localparam int POP_W         = 4;

	localparam logic [WB_W-1:0] WB_WIDE = 2'd2;

	typedef enum logic [IDX_W-1:0] {
		REG_WEIGHT_BYTES = 2'd0,
		REG_VECTOR_COUNT = 2'd1,
		REG_CHUNK_STEPS  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic flush;
		logic fresh;
	} ctl_t;

	function automatic logic [CNT_W-1:0] chunk_limit(input logic [CSTEP_W-1:0] steps);
		logic [CSTEP_W-1:0] s;
		s = steps;
		if (s == '0)
			s = CSTEP_W'(1);
		else if (s > CSTEP_W'(MAX_CHUNK))
			s = CSTEP_W'(MAX_CHUNK);
		return CNT_W'({s, {STEP_SHIFT{1'b0}}});
	endfunction

	function automatic logic [LANES-1:0] active_mask(input logic [VC_W-1:0] vc);
		logic [VC_W-1:0] n;
		logic [LANES-1:0] m;
		n = vc;
		if (n == '0)
			n = VC_W'(1);
		else if (n > VC_W'(LANES))
			n = VC_W'(LANES);
		for (int i = 0; i < LANES; i++)
			m[i] = (VC_W'(i) < n);
		return m;
	endfunction

	function automatic logic [POP_W-1:0] popcount(input logic [LANES-1:0] v);
		logic [POP_W-1:0] c;
		c = '0;
		for (int i = 0; i < LANES; i++)
			c = c + POP_W'(v[i]);
		return c;
	endfunction

endpackage

FILE: hdl/amcs_ctrl.sv
module amcs_ctrl
	import amcs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic                     last_of_row,
	input  logic signed [TOT_W-1:0]  bias,
	input  logic [CSTEP_W-1:0]       chunk_steps,
	output ctl_t                     ctl_s1,
	output ctl_t                     ctl_s2,
	output ctl_t                     ctl_s3,
	output logic [TOT_W-1:0]         bias_s2
);

	logic             acc;
	logic             first;
	logic             flush;
	logic [CNT_W-1:0] cnt_next;
	logic [CNT_W-1:0] count_q;
	logic             row_open_q;
	logic             unflushed_q;
	logic [TOT_W-1:0] row_bias_q;
	logic [TOT_W-1:0] bias_s1;

	assign acc      = in_valid && en;
	assign first    = !row_open_q;
	assign cnt_next = count_q + CNT_W'(1);
	assign flush    = last_of_row || (cnt_next >= chunk_limit(chunk_steps));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			ctl_s3      <= '0;
			count_q     <= '0;
			row_open_q  <= 1'b0;
			unflushed_q <= 1'b0;
		end else begin
			if (en) begin
				ctl_s1.valid <= acc;
				ctl_s1.last  <= last_of_row;
				ctl_s1.flush <= flush;
				ctl_s1.fresh <= flush && (first || unflushed_q);
				ctl_s2       <= ctl_s1;
				ctl_s3       <= ctl_s2;
			end
			if (acc) begin
				count_q     <= flush ? '0 : cnt_next;
				row_open_q  <= !last_of_row;
				unflushed_q <= flush ? 1'b0 : (first ? 1'b1 : unflushed_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && first)
			row_bias_q <= bias;
		if (en) begin
			bias_s1 <= first ? bias : row_bias_q;
			bias_s2 <= bias_s1;
		end
	end

endmodule

FILE: hdl/amcs_lane.sv
module amcs_lane
	import amcs_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    active,
	input  logic signed [W_W-1:0]   weight,
	input  logic signed [S_W-1:0]   sample,
	input  ctl_t                    ctl_s1,
	input  ctl_t                    ctl_s2,
	input  logic [TOT_W-1:0]        bias_s2,
	output logic [TOT_W-1:0]        total,
	output logic                    sat_s3
);

	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [CS_W-1:0]   acc_c;
	logic signed [CS_W-1:0]   cs_q;
	logic signed [CS_W-1:0]   pend_s2;
	logic [TOT_W-1:0]         base_c;
	logic [SUM_W-1:0]         sum_c;
	logic [SUM_W-TOT_W:0]     hi_c;
	logic                     ovf_c;
	logic [TOT_W-1:0]         clamp_c;
	logic [TOT_W-1:0]         total_q;

	assign prod_c = $signed({{S_W{weight[W_W-1]}}, weight})
		* $signed({{W_W{sample[S_W-1]}}, sample});
	assign acc_c  = cs_q + CS_W'(prod_s1);

	assign base_c  = ctl_s2.fresh ? bias_s2 : total_q;
	assign sum_c   = {{(SUM_W-TOT_W){base_c[TOT_W-1]}}, base_c} + {pend_s2[CS_W-1], pend_s2};
	assign hi_c    = sum_c[SUM_W-1:TOT_W-1];
	assign ovf_c   = !((hi_c == '0) || (hi_c == '1));
	assign clamp_c = !ovf_c ? sum_c[TOT_W-1:0]
		: (sum_c[SUM_W-1] ? {1'b1, {(TOT_W-1){1'b0}}} : {1'b0, {(TOT_W-1){1'b1}}});

	assign total = total_q;

	always_ff @(posedge clk) begin
		if (en)
			prod_s1 <= active ? prod_c : '0;
		if (en && ctl_s1.valid && ctl_s1.flush)
			pend_s2 <= acc_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q    <= '0;
			total_q <= '0;
			sat_s3  <= 1'b0;
		end else if (en) begin
			if (ctl_s1.valid)
				cs_q <= ctl_s1.flush ? '0 : acc_c;
			sat_s3 <= 1'b0;
			if (ctl_s2.valid && ctl_s2.flush) begin
				total_q <= clamp_c;
				sat_s3  <= ovf_c;
			end
		end
	end

endmodule

FILE: hdl/amcs_merge.sv
`include "affine_mac_with_chunk_saturation_unit_assert.svh"

module amcs_merge
	import amcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_t                 ctl_s3,
	input  logic [LANES-1:0]     sat_s3,
	input  logic [TOT_W-1:0]     total [LANES],
	input  logic [LANES-1:0]     active,
	input  logic                 out_stall,
	output logic                 en,
	output logic                 out_valid,
	output logic [TOT_W-1:0]     out_word [LANES],
	output logic [TOT_W-1:0]     saturation_events
);

	logic             load;
	logic [TOT_W-1:0] clamp_next;
	logic [TOT_W-1:0] clamp_q;
	logic             out_valid_q;

	assign en         = !(out_valid_q && out_stall && ctl_s3.valid && ctl_s3.last);
	assign load       = en && ctl_s3.valid && ctl_s3.last;
	assign clamp_next = clamp_q + TOT_W'(popcount(sat_s3));
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (en && ctl_s3.valid)
				clamp_q <= clamp_next;
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < LANES; i++)
				out_word[i] <= active[i] ? total[i] : '0;
			saturation_events <= clamp_next;
		end
	end

	`AMCS_ASSERT_IMP(a_sat_needs_flush, (sat_s3 != '0), (ctl_s3.valid && ctl_s3.flush), "clamp flag without flush")
	`AMCS_ASSERT_IMP(a_row_end_flushes, (ctl_s3.valid && ctl_s3.last), ctl_s3.flush, "row end without flush")
	`AMCS_ASSERT_NXT(a_count_hold, (!(en && ctl_s3.valid && ctl_s3.flush)), $stable(clamp_q), "clamp count moved without flush")

endmodule

FILE: hdl/affine_mac_with_chunk_saturation_unit.sv
// channel | handshake                | payload
// input   | in_valid / in_stall      | weight, sample_0..7, bias, last_of_row
// output  | out_valid / out_stall    | out_0..7, saturation_events
// config  | cfg_we                   | cfg_index, cfg_data
//
// One word per cycle in while in_stall is low; pipeline is multiply, chunk accumulate, flush/clamp, output.
// A row-end word passes the multiply, accumulate and clamp registers, then the output register.
// Reset clears lane totals, chunk sums, element count, row state and the clamp count.
// in_stall rises only while the output register holds a stalled result and the
// next row end is waiting behind it; other words keep moving.

module affine_mac_with_chunk_saturation_unit
	import amcs_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [W_W-1:0]      weight,
	input  logic signed [S_W-1:0]      sample_0,
	input  logic signed [S_W-1:0]      sample_1,
	input  logic signed [S_W-1:0]      sample_2,
	input  logic signed [S_W-1:0]      sample_3,
	input  logic signed [S_W-1:0]      sample_4,
	input  logic signed [S_W-1:0]      sample_5,
	input  logic signed [S_W-1:0]      sample_6,
	input  logic signed [S_W-1:0]      sample_7,
	input  logic signed [TOT_W-1:0]    bias,
	input  logic                       last_of_row,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [TOT_W-1:0]    out_0,
	output logic signed [TOT_W-1:0]    out_1,
	output logic signed [TOT_W-1:0]    out_2,
	output logic signed [TOT_W-1:0]    out_3,
	output logic signed [TOT_W-1:0]    out_4,
	output logic signed [TOT_W-1:0]    out_5,
	output logic signed [TOT_W-1:0]    out_6,
	output logic signed [TOT_W-1:0]    out_7,
	output logic [TOT_W-1:0]           saturation_events,
	input  logic                       cfg_we,
	input  logic [IDX_W-1:0]           cfg_index,
	input  logic [CSTEP_W-1:0]         cfg_data
);

	logic [WB_W-1:0]       weight_bytes_q;
	logic [VC_W-1:0]       vector_count_q;
	logic [CSTEP_W-1:0]    chunk_steps_q;
	logic                  en;
	logic signed [W_W-1:0] w_sel;
	logic [LANES-1:0]      active;
	logic signed [S_W-1:0] samples [LANES];
	logic [TOT_W-1:0]      total [LANES];
	logic [LANES-1:0]      sat_s3;
	logic [TOT_W-1:0]      out_word [LANES];
	ctl_t                  ctl_s1;
	ctl_t                  ctl_s2;
	ctl_t                  ctl_s3;
	logic [TOT_W-1:0]      bias_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_bytes_q <= WB_W'(1);
			vector_count_q <= VC_W'(1);
			chunk_steps_q  <= CSTEP_W'(64);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WEIGHT_BYTES: weight_bytes_q <= cfg_data[WB_W-1:0];
				REG_VECTOR_COUNT: vector_count_q <= cfg_data[VC_W-1:0];
				REG_CHUNK_STEPS:  chunk_steps_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_sel    = (weight_bytes_q == WB_WIDE) ? weight
		: {{(W_W-S_W){weight[S_W-1]}}, weight[S_W-1:0]};
	assign active   = active_mask(vector_count_q);
	assign in_stall = !en;

	assign samples[0] = sample_0;
	assign samples[1] = sample_1;
	assign samples[2] = sample_2;
	assign samples[3] = sample_3;
	assign samples[4] = sample_4;
	assign samples[5] = sample_5;
	assign samples[6] = sample_6;
	assign samples[7] = sample_7;

	amcs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (in_valid),
		.last_of_row (last_of_row),
		.bias        (bias),
		.chunk_steps (chunk_steps_q),
		.ctl_s1      (ctl_s1),
		.ctl_s2      (ctl_s2),
		.ctl_s3      (ctl_s3),
		.bias_s2     (bias_s2)
	);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		amcs_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.active  (active[i]),
			.weight  (w_sel),
			.sample  (samples[i]),
			.ctl_s1  (ctl_s1),
			.ctl_s2  (ctl_s2),
			.bias_s2 (bias_s2),
			.total   (total[i]),
			.sat_s3  (sat_s3[i])
		);
	end

	amcs_merge u_merge (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl_s3            (ctl_s3),
		.sat_s3            (sat_s3),
		.total             (total),
		.active            (active),
		.out_stall         (out_stall),
		.en                (en),
		.out_valid         (out_valid),
		.out_word          (out_word),
		.saturation_events (saturation_events)
	);

	assign out_0 = out_word[0];
	assign out_1 = out_word[1];
	assign out_2 = out_word[2];
	assign out_3 = out_word[3];
	assign out_4 = out_word[4];
	assign out_5 = out_word[5];
	assign out_6 = out_word[6];
	assign out_7 = out_word[7];

endmodule
